FILE: src/cttok_pkg.sv
// Shared constants, result types and character classes of the config text tokenizer.
`default_nettype none

package cttok_pkg;

    localparam int LINE_BITS_DEF = 16;
    localparam int CHAR_W        = 8;
    localparam int KIND_W        = 3;
    localparam int LINE_NO_W     = 16;
    localparam int ERR_W         = 3;

    localparam logic [KIND_W-1:0] K_CHAR  = 3'd0;
    localparam logic [KIND_W-1:0] K_EOW   = 3'd1;
    localparam logic [KIND_W-1:0] K_OPEN  = 3'd2;
    localparam logic [KIND_W-1:0] K_CLOSE = 3'd3;
    localparam logic [KIND_W-1:0] K_SEMI  = 3'd4;
    localparam logic [KIND_W-1:0] K_ERR   = 3'd5;

    localparam logic [ERR_W-1:0] E_NONE      = 3'd0;
    localparam logic [ERR_W-1:0] E_ESC_END   = 3'd1;
    localparam logic [ERR_W-1:0] E_UNCLOSED  = 3'd2;
    localparam logic [ERR_W-1:0] E_AFTER_Q   = 3'd3;
    localparam logic [ERR_W-1:0] E_Q_IN_WORD = 3'd4;

    localparam logic [CHAR_W-1:0] C_TAB    = 8'h09;
    localparam logic [CHAR_W-1:0] C_LF     = 8'h0A;
    localparam logic [CHAR_W-1:0] C_CR     = 8'h0D;
    localparam logic [CHAR_W-1:0] C_SPACE  = 8'h20;
    localparam logic [CHAR_W-1:0] C_DQ     = 8'h22;
    localparam logic [CHAR_W-1:0] C_HASH   = 8'h23;
    localparam logic [CHAR_W-1:0] C_SQ     = 8'h27;
    localparam logic [CHAR_W-1:0] C_SEMI   = 8'h3B;
    localparam logic [CHAR_W-1:0] C_BSLASH = 8'h5C;
    localparam logic [CHAR_W-1:0] C_LOW_N  = 8'h6E;
    localparam logic [CHAR_W-1:0] C_LOW_R  = 8'h72;
    localparam logic [CHAR_W-1:0] C_LOW_T  = 8'h74;
    localparam logic [CHAR_W-1:0] C_LBRACE = 8'h7B;
    localparam logic [CHAR_W-1:0] C_RBRACE = 8'h7D;

    typedef struct packed {
        logic [KIND_W-1:0]    kind;
        logic [CHAR_W-1:0]    char_out;
        logic [LINE_NO_W-1:0] line_no;
        logic [ERR_W-1:0]     error_code;
        logic                 last;
    } t_result;

    typedef struct packed {
        logic [1:0] count;
        t_result    res0;
        t_result    res1;
    } t_step;

    function automatic logic is_space(input logic [CHAR_W-1:0] c);
        return (c == C_SPACE) || (c == C_TAB) || (c == C_CR) || (c == C_LF);
    endfunction

    function automatic logic is_quote(input logic [CHAR_W-1:0] c);
        return (c == C_DQ) || (c == C_SQ);
    endfunction

    function automatic logic is_directive(input logic [CHAR_W-1:0] c);
        return (c == C_LBRACE) || (c == C_RBRACE) || (c == C_SEMI);
    endfunction

    function automatic logic [KIND_W-1:0] dir_kind(input logic [CHAR_W-1:0] c);
        return (c == C_LBRACE) ? K_OPEN : ((c == C_RBRACE) ? K_CLOSE : K_SEMI);
    endfunction

endpackage

`default_nettype wire

FILE: src/cttok_in_if.sv
// Input channel of the tokenizer: one file byte or an end-of-file mark per beat.
`default_nettype none

interface cttok_in_if;
    logic       valid;
    logic       ready;
    logic       cmd;
    logic [7:0] char_in;

    modport source (output valid, output cmd, output char_in, input ready);
    modport sink   (input valid, input cmd, input char_in, output ready);
endinterface

`default_nettype wire

FILE: src/cttok_out_if.sv
// Output channel of the tokenizer: one token result per beat.
`default_nettype none

interface cttok_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [7:0]  char_out;
    logic [15:0] line_no;
    logic [2:0]  error_code;
    logic        last;

    modport source (output valid, output kind, output char_out, output line_no,
                    output error_code, output last, input ready);
    modport sink   (input valid, input kind, input char_out, input line_no,
                    input error_code, input last, output ready);
endinterface

`default_nettype wire

FILE: src/cttok_cfg_if.sv
// Configuration write channel of the tokenizer carrying the first line number.
`default_nettype none

interface cttok_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: src/cttok_lex.sv
// Lexer state and the per-byte step that yields up to two token results.
`default_nettype none

module cttok_lex
    import cttok_pkg::*;
#(
    parameter int LINE_BITS = LINE_BITS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_fire,
    input  wire logic                 i_cmd,
    input  wire logic [CHAR_W-1:0]    i_char,
    input  wire logic [LINE_NO_W-1:0] i_first_line,
    output t_step                     o_step
);

    localparam logic [2:0] M_BETWEEN = 3'd0;
    localparam logic [2:0] M_COMMENT = 3'd1;
    localparam logic [2:0] M_WORD    = 3'd2;
    localparam logic [2:0] M_QUOTED  = 3'd3;
    localparam logic [2:0] M_ESCAPE  = 3'd4;
    localparam logic [2:0] M_AFTERQ  = 3'd5;
    localparam logic [2:0] M_ERROR   = 3'd6;

    localparam logic [32:0] LINE_MAX = (33'd1 << LINE_BITS) - 33'd1;

    logic [2:0]           r_mode;
    logic [2:0]           n_mode;
    logic                 r_dq;
    logic                 n_dq;
    logic [LINE_BITS-1:0] r_count;
    logic [LINE_BITS-1:0] n_count;

    logic                 w_bump;
    logic                 w_load;
    logic [LINE_BITS-1:0] w_count_inc;
    logic [LINE_BITS-1:0] w_load_val;
    logic [32:0]          w_first_ext;
    logic [LINE_NO_W-1:0] w_line_cur;
    logic [LINE_NO_W-1:0] w_line_lf;
    logic [CHAR_W-1:0]    w_qc;
    t_step                w_step;

    assign w_first_ext = 33'(i_first_line);
    assign w_load_val  = (w_first_ext > LINE_MAX) ? LINE_MAX[LINE_BITS-1:0]
                                                  : w_first_ext[LINE_BITS-1:0];
    assign w_count_inc = (r_count == LINE_MAX[LINE_BITS-1:0]) ? r_count
                                                              : r_count + LINE_BITS'(1);
    assign w_line_cur  = LINE_NO_W'(r_count);
    assign w_line_lf   = (i_char == C_LF) ? LINE_NO_W'(w_count_inc) : w_line_cur;
    assign w_qc        = r_dq ? C_DQ : C_SQ;

    always_comb begin
        w_step              = '0;
        w_step.res0.line_no = w_line_cur;
        w_step.res1.line_no = w_line_cur;
        n_mode              = r_mode;
        n_dq                = r_dq;
        w_bump              = 1'b0;
        w_load              = 1'b0;
        if (i_cmd) begin
            if (r_mode == M_WORD || r_mode == M_AFTERQ) begin
                w_step.res0.kind = K_EOW;
                w_step.count     = 2'd1;
            end else if (r_mode == M_QUOTED) begin
                w_step.res0.kind       = K_ERR;
                w_step.res0.error_code = E_UNCLOSED;
                w_step.count           = 2'd1;
            end else if (r_mode == M_ESCAPE) begin
                w_step.res0.kind       = K_ERR;
                w_step.res0.error_code = E_ESC_END;
                w_step.count           = 2'd1;
            end
            n_mode = M_BETWEEN;
            n_dq   = 1'b0;
            w_load = 1'b1;
        end else begin
            unique case (r_mode)
                M_BETWEEN: begin
                    if (is_space(i_char)) begin
                        w_bump = (i_char == C_LF);
                    end else if (i_char == C_HASH) begin
                        n_mode = M_COMMENT;
                    end else if (is_quote(i_char)) begin
                        n_mode = M_QUOTED;
                        n_dq   = (i_char == C_DQ);
                    end else if (is_directive(i_char)) begin
                        w_step.res0.kind     = dir_kind(i_char);
                        w_step.res0.char_out = i_char;
                        w_step.count         = 2'd1;
                    end else begin
                        n_mode               = M_WORD;
                        w_step.res0.kind     = K_CHAR;
                        w_step.res0.char_out = i_char;
                        w_step.count         = 2'd1;
                    end
                end
                M_COMMENT: begin
                    if (i_char == C_LF) begin
                        w_bump = 1'b1;
                        n_mode = M_BETWEEN;
                    end
                end
                M_WORD, M_AFTERQ: begin
                    if (is_space(i_char) || is_directive(i_char)) begin
                        n_mode           = M_BETWEEN;
                        w_bump           = (i_char == C_LF);
                        w_step.res0.kind = K_EOW;
                        w_step.count     = 2'd1;
                        if (is_directive(i_char)) begin
                            w_step.res1.kind     = dir_kind(i_char);
                            w_step.res1.char_out = i_char;
                            w_step.count         = 2'd2;
                        end
                    end else if (r_mode == M_AFTERQ) begin
                        n_mode                 = M_ERROR;
                        w_step.res0.kind       = K_ERR;
                        w_step.res0.char_out   = i_char;
                        w_step.res0.error_code = E_AFTER_Q;
                        w_step.count           = 2'd1;
                    end else if (is_quote(i_char)) begin
                        n_mode                 = M_ERROR;
                        w_step.res0.kind       = K_ERR;
                        w_step.res0.char_out   = i_char;
                        w_step.res0.error_code = E_Q_IN_WORD;
                        w_step.count           = 2'd1;
                    end else begin
                        w_step.res0.kind     = K_CHAR;
                        w_step.res0.char_out = i_char;
                        w_step.count         = 2'd1;
                    end
                end
                M_QUOTED: begin
                    if (r_dq && i_char == C_BSLASH) begin
                        n_mode = M_ESCAPE;
                    end else begin
                        w_bump = (i_char == C_LF);
                        if (i_char == w_qc) begin
                            n_mode = M_AFTERQ;
                        end else begin
                            w_step.res0.kind     = K_CHAR;
                            w_step.res0.char_out = i_char;
                            w_step.res0.line_no  = w_line_lf;
                            w_step.count         = 2'd1;
                        end
                    end
                end
                M_ESCAPE: begin
                    n_mode           = M_QUOTED;
                    w_step.res0.kind = K_CHAR;
                    w_step.count     = 2'd1;
                    priority if (i_char == C_DQ || i_char == C_BSLASH) begin
                        w_step.res0.char_out = i_char;
                    end else if (i_char == C_LOW_N) begin
                        w_step.res0.char_out = C_LF;
                    end else if (i_char == C_LOW_R) begin
                        w_step.res0.char_out = C_CR;
                    end else if (i_char == C_LOW_T) begin
                        w_step.res0.char_out = C_TAB;
                    end else begin
                        // Unknown escape: keep the backslash, then the byte as plain text.
                        w_step.res0.char_out = C_BSLASH;
                        w_bump               = (i_char == C_LF);
                        w_step.res1.kind     = K_CHAR;
                        w_step.res1.char_out = i_char;
                        w_step.res1.line_no  = w_line_lf;
                        w_step.count         = 2'd2;
                    end
                end
                default: begin
                    n_mode = M_ERROR;
                end
            endcase
        end
        w_step.res0.last = (w_step.count == 2'd1);
        w_step.res1.last = 1'b1;
    end

    always_comb begin
        if (w_load) begin
            n_count = w_load_val;
        end else if (w_bump) begin
            n_count = w_count_inc;
        end else begin
            n_count = r_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= M_BETWEEN;
            r_dq    <= 1'b0;
            r_count <= LINE_BITS'(1);
        end else if (i_fire) begin
            r_mode  <= n_mode;
            r_dq    <= n_dq;
            r_count <= n_count;
        end
    end

    assign o_step = w_step;

endmodule

`default_nettype wire

FILE: src/config_text_tokenizer_core.sv
// Top level of the config text tokenizer: input register, lexer and result queue.
//
// Input beats on i_in carry one file byte (cmd 0) or an end-of-file mark (cmd 1).
// Every beat yields zero, one or two results on o_out; last marks the final one.
// Results are word characters, end of word, brace and semicolon tokens, or errors.
// An error makes the lexer drop all bytes until the next end-of-file beat.
// The first line number is written on i_cfg; it takes effect after each
// end-of-file beat. Write it only while the block is idle.
// A beat accepted on i_in is held in the input register; the lexer turns it
// into results that are registered in the result queue, which drives o_out.
// Throughput: one input beat per cycle while o_out does not stall and each beat
// gives at most one result; a beat with two results holds the output port until
// both have moved, since o_out moves one result per cycle.
// The result queue holds two entries, so i_in keeps taking beats while a
// result waits; when o_out stalls, the queue fills and i_in.ready drops.
// Reset empties the queue and input register and sets the line count to 1.
`default_nettype none

module config_text_tokenizer_core
    import cttok_pkg::*;
#(
    parameter int LINE_BITS = LINE_BITS_DEF
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    cttok_in_if.sink      i_in,
    cttok_cfg_if.sink     i_cfg,
    cttok_out_if.source   o_out
);

    logic                 r_in_vld;
    logic                 r_in_cmd;
    logic [CHAR_W-1:0]    r_in_char;
    logic [LINE_NO_W-1:0] r_first_line;
    logic [1:0]           r_cnt;
    logic [1:0]           n_cnt;
    t_result              r_slot0;
    t_result              n_slot0;
    t_result              r_slot1;
    t_result              n_slot1;

    t_step                w_step;
    logic                 w_pop;
    logic [1:0]           w_rem;
    logic [2:0]           w_need;
    logic                 w_fire;
    t_result              w_kept0;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_line <= LINE_NO_W'(1);
        end else if (i_cfg.valid) begin
            r_first_line <= i_cfg.data;
        end
    end

    assign i_in.ready = !r_in_vld || w_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_in.ready) begin
            r_in_vld <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_cmd  <= i_in.cmd;
            r_in_char <= i_in.char_in;
        end
    end

    cttok_lex #(
        .LINE_BITS (LINE_BITS)
    ) u_lex (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (w_fire),
        .i_cmd        (r_in_cmd),
        .i_char       (r_in_char),
        .i_first_line (r_first_line),
        .o_step       (w_step)
    );

    assign w_pop   = (r_cnt != 2'd0) && o_out.ready;
    assign w_rem   = r_cnt - {1'b0, w_pop};
    assign w_need  = {1'b0, w_rem} + {1'b0, w_step.count};
    assign w_fire  = r_in_vld && (w_need <= 3'd2);
    assign w_kept0 = w_pop ? r_slot1 : r_slot0;

    always_comb begin
        n_slot0 = w_kept0;
        n_slot1 = r_slot1;
        n_cnt   = w_rem;
        if (w_fire) begin
            n_cnt = w_need[1:0];
            if (w_rem == 2'd0) begin
                n_slot0 = w_step.res0;
                n_slot1 = w_step.res1;
            end else if (w_rem == 2'd1) begin
                n_slot1 = w_step.res0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot0 <= n_slot0;
        r_slot1 <= n_slot1;
    end

    assign o_out.valid      = (r_cnt != 2'd0);
    assign o_out.kind       = r_slot0.kind;
    assign o_out.char_out   = r_slot0.char_out;
    assign o_out.line_no    = r_slot0.line_no;
    assign o_out.error_code = r_slot0.error_code;
    assign o_out.last       = r_slot0.last;

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("Result queue count out of range.");

    a_pair_queued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt != 2'd0 && !r_slot0.last) |-> (r_cnt == 2'd2))
        else $error("First result of a pair is shown without its partner queued.");

    a_err_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> ((o_out.kind == K_ERR) == (o_out.error_code != E_NONE)))
        else $error("Error code does not match result kind.");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && !w_fire) |=> r_in_vld)
        else $error("Input beat dropped without being processed.");

endmodule

`default_nettype wire
